@@ rtl/core/es2dt_pkg.sv @@
// Shared types, constants and calendar helpers for the epoch to date/time converter.
package es2dt_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaysCommon  = 365;
  localparam int unsigned FirstYear   = 1970;
  localparam int unsigned CenturyNoLeap = 2100;

  localparam int unsigned InW    = 32;
  localparam int unsigned RemW   = 17;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonW   = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned OutDataW = 40;

  // floor(x / d) = (x * R) >> S over the full operand range
  localparam logic [25:0] DayRecip  = 26'd50903317;  // x = secs >> 7, d = 675, S = 35
  localparam logic [13:0] HourRecip = 14'd9321;      // x = tod >> 4,  d = 225, S = 21
  localparam logic [10:0] MinRecip  = 11'd1093;      // x = rem >> 2,  d = 15,  S = 14

  localparam logic [MonW-1:0] LastMonIdx = 4'd11;
  localparam logic [MonW-1:0] FebIdx     = 4'd1;

  typedef struct packed {
    logic load_in;
    logic day_quo;
    logic day_rem;
    logic hour_quo;
    logic hour_rem;
    logic min_quo;
    logic min_rem;
    logic yr_step;
    logic mo_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic yr_fits;
    logic mo_fits;
  } stat_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] idx,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      FebIdx:                                    len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/es2dt_dpath.sv @@
// Datapath: reciprocal dividers, year/month stepping and result register.
module es2dt_dpath (
  input  logic                              clk,
  input  logic [es2dt_pkg::InW-1:0]         in_data,
  input  es2dt_pkg::cmd_t                   cmd,
  output es2dt_pkg::stat_t                  stat,
  output logic [es2dt_pkg::OutDataW-1:0]    out_data
);
  import es2dt_pkg::*;

  logic [InW-1:0]      secs_r, secs_nxt;
  logic [RemW-1:0]     rem_r, rem_nxt;
  logic [DaysW-1:0]    days_r, days_nxt;
  logic [YearW-1:0]    year_r, year_nxt;
  logic [MonW-1:0]     mon_r, mon_nxt;
  logic [HourW-1:0]    hour_r, hour_nxt;
  logic [MinW-1:0]     min_r, min_nxt;
  logic [SecW-1:0]     sec_r, sec_nxt;
  logic [OutDataW-1:0] out_r, out_nxt;

  logic [50:0]     day_prod;
  logic [26:0]     hour_prod;
  logic [20:0]     min_prod;
  logic [RemW-1:0] day_back;
  logic [11:0]     hour_back;
  logic [SecW-1:0] min_back;
  logic            leap;
  logic [8:0]      ylen;
  logic [DayW-1:0] mlen;
  logic [DayW-1:0] day_of_mon;

  assign day_prod  = 51'(secs_r[InW-1:7]) * 51'(DayRecip);
  assign hour_prod = 27'(rem_r[RemW-1:4]) * 27'(HourRecip);
  assign min_prod  = 21'(rem_r[11:2]) * 21'(MinRecip);

  // multiply back modulo the width of the field each product is subtracted from
  assign day_back  = RemW'(days_r) * RemW'(SecsPerDay);
  assign hour_back = 12'(hour_r) * 12'(SecsPerHour);
  assign min_back  = SecW'(min_r) * SecW'(SecsPerMin);

  assign leap = (year_r[1:0] == 2'b00) && (year_r != YearW'(CenturyNoLeap));
  assign ylen = 9'(DaysCommon) + {8'd0, leap};
  assign mlen = month_len(mon_r, leap);
  assign day_of_mon = days_r[DayW-1:0] + 5'd1;

  assign stat.yr_fits  = days_r >= {7'd0, ylen};
  assign stat.mo_fits  = (mon_r != LastMonIdx) && (days_r >= {11'd0, mlen});

  always_comb begin
    secs_nxt = secs_r;
    rem_nxt  = rem_r;
    days_nxt = days_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    out_nxt  = out_r;
    if (cmd.load_in) begin
      secs_nxt = in_data;
      year_nxt = YearW'(FirstYear);
      mon_nxt  = '0;
    end
    if (cmd.day_quo) begin
      days_nxt = day_prod[50:35];
    end
    if (cmd.day_rem) begin
      rem_nxt = secs_r[RemW-1:0] - day_back;
    end
    if (cmd.hour_quo) begin
      hour_nxt = hour_prod[25:21];
    end
    if (cmd.hour_rem) begin
      rem_nxt = {5'd0, rem_r[11:0] - hour_back};
    end
    if (cmd.min_quo) begin
      min_nxt = min_prod[19:14];
    end
    if (cmd.min_rem) begin
      sec_nxt = rem_r[SecW-1:0] - min_back;
    end
    if (cmd.yr_step) begin
      days_nxt = days_r - {7'd0, ylen};
      year_nxt = year_r + 1'b1;
    end
    if (cmd.mo_step) begin
      days_nxt = days_r - {11'd0, mlen};
      mon_nxt  = mon_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_nxt = {2'b00, sec_r, min_r, hour_r, day_of_mon, mon_r + 4'd1, year_r};
    end
  end

  always_ff @(posedge clk) begin
    secs_r <= secs_nxt;
    rem_r  <= rem_nxt;
    days_r <= days_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule

@@ rtl/core/es2dt_ctrl.sv @@
// Controller: sequences division, year and month steps, and owns the output handshake.
module es2dt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  es2dt_pkg::stat_t  stat,
  output es2dt_pkg::cmd_t   cmd
);
  import es2dt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DDAY,
    S_HSET,
    S_DHOUR,
    S_MSET,
    S_DMIN,
    S_SSET,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DDAY;
        end
      end
      S_DDAY: begin
        cmd.day_quo = 1'b1;
        state_nxt   = S_HSET;
      end
      S_HSET: begin
        cmd.day_rem = 1'b1;
        state_nxt   = S_DHOUR;
      end
      S_DHOUR: begin
        cmd.hour_quo = 1'b1;
        state_nxt    = S_MSET;
      end
      S_MSET: begin
        cmd.hour_rem = 1'b1;
        state_nxt    = S_DMIN;
      end
      S_DMIN: begin
        cmd.min_quo = 1'b1;
        state_nxt   = S_SSET;
      end
      S_SSET: begin
        cmd.min_rem = 1'b1;
        state_nxt   = S_YEAR;
      end
      S_YEAR: begin
        if (stat.yr_fits) cmd.yr_step = 1'b1;
        else state_nxt = S_MONTH;
      end
      S_MONTH: begin
        if (stat.mo_fits) cmd.mo_step = 1'b1;
        else state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

@@ rtl/core/epoch_seconds_to_date_time.sv @@
// Top level: unsigned epoch seconds in, UTC calendar date and time of day out.
//
// One beat in gives one beat out. After the accepting edge the controller runs the division
// states DDAY, HSET, DHOUR, MSET, DMIN and SSET, then YEAR and MONTH until no whole year or
// month is left, and then DONE, which loads the result register. The whole years past 1970
// plus the whole months past January in the last year are at most 146 (December 2105). The
// three divisions (by 86400, 3600 and 60) are each a reciprocal multiply and a multiply-back
// subtract, each step in a state of its own, and the year and month reductions step one year
// or one month a cycle. One item is in work at a time and input ready returns the cycle after
// the result is loaded. A finished result waits in the output register while the next beat is
// accepted; if it still waits when the next conversion ends, the block holds.
module epoch_seconds_to_date_time (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [11:0] cal_year, [15:12] cal_month, [20:16] cal_day,
                                  // [25:21] hour_of_day, [31:26] minute_of_hour,
                                  // [37:32] second_of_minute, [39:38] zero
);
  import es2dt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  es2dt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  es2dt_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_tdata)
  );

endmodule

@@ rtl/core/es2dt_checker.sv @@
// Port-level checker for the epoch to date/time converter, bound to the top level.
module es2dt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted beat");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:0] >= 12'd1970 && out_tdata[11:0] <= 12'd2106 &&
                   out_tdata[15:12] >= 4'd1 && out_tdata[15:12] <= 4'd12 &&
                   out_tdata[20:16] >= 5'd1 && out_tdata[20:16] <= 5'd31)
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:21] <= 5'd23 && out_tdata[31:26] <= 6'd59 &&
                   out_tdata[37:32] <= 6'd59 && out_tdata[39:38] == 2'b00)
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_date_time es2dt_checker u_es2dt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
